### rtl/rgbnv_pkg.sv
package rgbnv_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int OFFSET_W   = 25;
    localparam int SAMPLE_W   = 8;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_PAIR_COLUMNS = 2'd0;
    localparam t_cfg_idx CFG_PAIR_ROWS    = 2'd1;

    localparam t_cfg_data PAIR_COLUMNS_RESET = 12'd960;
    localparam t_cfg_data PAIR_ROWS_RESET    = 12'd540;

    // Sample kind on the result channel; also the beat state of the output stage.
    typedef enum logic [1:0] {
        KIND_LUMA = 2'd0,
        KIND_CB   = 2'd1,
        KIND_CR   = 2'd2
    } t_kind;

endpackage

### rtl/rgb_to_nv12_converter_top.sv
// RGB to NV12 converter, full-range BT.709. Feed the pixels of a region of
// (2*pair_columns) x (2*pair_rows) in raster order, one beat per pixel; the
// block returns one luma beat per pixel at its NV12 byte offset, and after the
// odd pixel of an odd row two more beats with the rounded 2x2 averages of Cb
// and then Cr at the interleaved chroma offsets. run_last marks the final beat
// of each pixel, frame_done the final beat of the region. A pixel is taken
// every clock while the result side keeps up, but the Cb and Cr beats of the
// odd pixel of an odd row hold off the next pixel. A pixel's first beat comes
// out of the stage 2 register after it passes the stage 1 register. The single
// result port moves one beat per clock while i_ready is high. Chroma pair
// sums of the even row live in a one-port-read, one-port-write line store of
// MAX_WIDTH/2 entries with registered read data; entries are written on the
// even row before the odd row reads them, so the store needs no clearing pass
// after reset. Sizes of 0 count as 1 and sizes above the parameter limits
// saturate. A size register write restarts the region at its first pixel;
// write configuration only while no pixel is in flight.
module rgb_to_nv12_converter_top #(
    parameter int MAX_WIDTH  = rgbnv_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgbnv_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_blue,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_red,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_sample_kind,
    output logic [rgbnv_pkg::OFFSET_W-1:0] o_buffer_offset,
    output logic [rgbnv_pkg::SAMPLE_W-1:0] o_sample_value,
    output logic                          o_run_last,
    output logic                          o_frame_done,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  rgbnv_pkg::t_cfg_idx           i_cfg_index,
    input  rgbnv_pkg::t_cfg_data          i_cfg_data
);
    import rgbnv_pkg::*;

    localparam int PAIRS_MAX  = MAX_WIDTH / 2;
    localparam int RPAIRS_MAX = MAX_HEIGHT / 2;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int PAW    = (PAIRS_MAX > 1) ? $clog2(PAIRS_MAX) : 1;
    localparam int AREA_W = WW + HW;
    localparam int LIM_W  = CFG_DATA_W + 2;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    t_cfg_data r_pair_cols;
    t_cfg_data r_pair_rows;
    logic      cfg_fire;
    logic      cfg_hit;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_fire &&
                         (i_cfg_index == CFG_PAIR_COLUMNS || i_cfg_index == CFG_PAIR_ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_cols <= PAIR_COLUMNS_RESET;
            r_pair_rows <= PAIR_ROWS_RESET;
        end else if (cfg_fire) begin
            if (i_cfg_index == CFG_PAIR_COLUMNS) begin
                r_pair_cols <= i_cfg_data;
            end else if (i_cfg_index == CFG_PAIR_ROWS) begin
                r_pair_rows <= i_cfg_data;
            end
        end
    end

    // Clamp sizes: zero counts as one, saturate at the parameter limit.
    logic [LIM_W-1:0] pc_lim;
    logic [LIM_W-1:0] pr_lim;
    logic [WW-1:0]    width;
    logic [HW-1:0]    height;

    always_comb begin
        if (r_pair_cols == '0) begin
            pc_lim = LIM_W'(1);
        end else if (LIM_W'(r_pair_cols) > LIM_W'(PAIRS_MAX)) begin
            pc_lim = LIM_W'(PAIRS_MAX);
        end else begin
            pc_lim = LIM_W'(r_pair_cols);
        end
        if (r_pair_rows == '0) begin
            pr_lim = LIM_W'(1);
        end else if (LIM_W'(r_pair_rows) > LIM_W'(RPAIRS_MAX)) begin
            pr_lim = LIM_W'(RPAIRS_MAX);
        end else begin
            pr_lim = LIM_W'(r_pair_rows);
        end
        width  = WW'({pc_lim, 1'b0});
        height = HW'({pr_lim, 1'b0});
    end

    // Luma plane size; used only at odd rows, long after any config write.
    logic [OFFSET_W-1:0] r_area;

    always_ff @(posedge i_clk) begin
        r_area <= OFFSET_W'(AREA_W'(width) * AREA_W'(height));
    end

    // ------------------------------------------------------------------
    // Accept side: position counters and line store read
    // ------------------------------------------------------------------
    logic [CW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    logic [OFFSET_W-1:0] r_luma_off;
    logic [OFFSET_W-1:0] r_crow;
    logic                col_last;
    logic                row_last;
    logic                i_fire;
    logic [PAW-1:0]      pair_idx;

    logic r_s1_v;
    logic s2_free;
    logic s1_go;

    assign o_ready  = !r_s1_v || s2_free;
    assign i_fire   = i_valid && o_ready;
    assign col_last = (r_col == CW'(width - WW'(1)));
    assign row_last = (r_row == RW'(height - HW'(1)));
    assign pair_idx = PAW'(r_col >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_luma_off <= '0;
            r_crow     <= '0;
        end else if (cfg_hit) begin
            r_col      <= '0;
            r_row      <= '0;
            r_luma_off <= '0;
            r_crow     <= '0;
        end else if (i_fire) begin
            if (col_last) begin
                r_col <= '0;
                if (row_last) begin
                    // wrap to the start of a new region
                    r_row      <= '0;
                    r_luma_off <= '0;
                    r_crow     <= '0;
                end else begin
                    r_row      <= r_row + RW'(1);
                    r_luma_off <= r_luma_off + OFFSET_W'(1);
                    if (r_row[0]) begin
                        r_crow <= r_crow + OFFSET_W'(width);
                    end
                end
            end else begin
                r_col      <= r_col + CW'(1);
                r_luma_off <= r_luma_off + OFFSET_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: color conversion, pair sums, line store write
    // ------------------------------------------------------------------
    logic [7:0]          r_s1_blue;
    logic [7:0]          r_s1_green;
    logic [7:0]          r_s1_red;
    logic                r_s1_col_odd;
    logic                r_s1_row_odd;
    logic                r_s1_last_px;
    logic [PAW-1:0]      r_s1_pair;
    logic [OFFSET_W-1:0] r_s1_luma_off;
    logic [OFFSET_W-1:0] r_s1_cofs;
    logic [17:0]         r_mem_q;

    logic [17:0] line_mem [PAIRS_MAX];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_fire) begin
            r_s1_v <= 1'b1;
        end else if (s1_go) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_s1_blue     <= i_blue;
            r_s1_green    <= i_green;
            r_s1_red      <= i_red;
            r_s1_col_odd  <= r_col[0];
            r_s1_row_odd  <= r_row[0];
            r_s1_last_px  <= col_last && row_last;
            r_s1_pair     <= pair_idx;
            r_s1_luma_off <= r_luma_off;
            r_s1_cofs     <= r_crow + OFFSET_W'(r_col & ~CW'(1));
        end
    end

    logic [7:0] s1_luma;
    logic [7:0] s1_cb;
    logic [7:0] s1_cr;
    logic [7:0] r_held_cb;
    logic [7:0] r_held_cr;
    logic [8:0] cb_pair;
    logic [8:0] cr_pair;
    logic       s1_chroma;

    rgbnv_csc u_csc (
        .i_blue  (r_s1_blue),
        .i_green (r_s1_green),
        .i_red   (r_s1_red),
        .o_luma  (s1_luma),
        .o_cb    (s1_cb),
        .o_cr    (s1_cr)
    );

    assign cb_pair   = 9'(r_held_cb) + 9'(s1_cb);
    assign cr_pair   = 9'(r_held_cr) + 9'(s1_cr);
    assign s1_chroma = r_s1_col_odd && r_s1_row_odd;
    assign s1_go     = r_s1_v && s2_free;

    // The read that the chroma pixel uses is issued at its accept edge; the even-row
    // write of the same pair leaves stage 1 at an earlier edge, so no forwarding.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_mem_q <= line_mem[pair_idx];
        end
        if (s1_go && r_s1_col_odd && !r_s1_row_odd) begin
            line_mem[r_s1_pair] <= {cr_pair, cb_pair};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cb <= '0;
            r_held_cr <= '0;
        end else if (s1_go && !r_s1_col_odd) begin
            r_held_cb <= s1_cb;
            r_held_cr <= s1_cr;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: result register, stalled by i_ready, one beat per clock
    // ------------------------------------------------------------------
    logic                r_s2_v;
    logic                r_s2_chroma;
    logic                r_s2_last_px;
    logic [7:0]          r_s2_luma;
    logic [OFFSET_W-1:0] r_s2_luma_off;
    logic [OFFSET_W-1:0] r_s2_cofs;
    logic [9:0]          r_s2_cb_sum;
    logic [9:0]          r_s2_cr_sum;
    t_kind               r_beat;
    t_kind               n_beat;
    logic                out_fire;
    logic                last_beat;

    assign out_fire = o_valid && i_ready;
    assign s2_free  = !r_s2_v || (out_fire && last_beat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_beat <= KIND_LUMA;
        end else begin
            r_beat <= n_beat;
            if (s1_go) begin
                r_s2_v <= 1'b1;
            end else if (s2_free) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_chroma   <= s1_chroma;
            r_s2_last_px  <= r_s1_last_px;
            r_s2_luma     <= s1_luma;
            r_s2_luma_off <= r_s1_luma_off;
            r_s2_cofs     <= r_s1_cofs;
            r_s2_cb_sum   <= 10'(r_mem_q[8:0]) + 10'(cb_pair);
            r_s2_cr_sum   <= 10'(r_mem_q[17:9]) + 10'(cr_pair);
        end
    end

    // beat sequence: luma, then Cb and Cr for the odd pixel of an odd row
    always_comb begin
        n_beat = r_beat;
        if (out_fire) begin
            unique case (r_beat)
                KIND_LUMA: n_beat = r_s2_chroma ? KIND_CB : KIND_LUMA;
                KIND_CB:   n_beat = KIND_CR;
                KIND_CR:   n_beat = KIND_LUMA;
                default:   n_beat = KIND_LUMA;
            endcase
        end
    end

    logic [OFFSET_W-1:0] chroma_base;
    logic [7:0]          cb_avg;
    logic [7:0]          cr_avg;

    assign chroma_base = r_area + r_s2_cofs;
    assign cb_avg      = 8'((r_s2_cb_sum + 10'd2) >> 2);
    assign cr_avg      = 8'((r_s2_cr_sum + 10'd2) >> 2);

    always_comb begin
        o_valid       = r_s2_v;
        o_sample_kind = r_beat;
        unique case (r_beat)
            KIND_LUMA: begin
                o_buffer_offset = r_s2_luma_off;
                o_sample_value  = r_s2_luma;
                last_beat       = !r_s2_chroma;
                o_frame_done    = !r_s2_chroma && r_s2_last_px;
            end
            KIND_CB: begin
                o_buffer_offset = chroma_base;
                o_sample_value  = cb_avg;
                last_beat       = 1'b0;
                o_frame_done    = 1'b0;
            end
            KIND_CR: begin
                o_buffer_offset = chroma_base + OFFSET_W'(1);
                o_sample_value  = cr_avg;
                last_beat       = 1'b1;
                o_frame_done    = r_s2_last_px;
            end
            default: begin
                o_buffer_offset = r_s2_luma_off;
                o_sample_value  = r_s2_luma;
                last_beat       = 1'b1;
                o_frame_done    = 1'b0;
            end
        endcase
        o_run_last = last_beat;
    end

endmodule

### rtl/rgbnv_csc.sv
module rgbnv_csc (
    input  logic [7:0] i_blue,
    input  logic [7:0] i_green,
    input  logic [7:0] i_red,
    output logic [7:0] o_luma,
    output logic [7:0] o_cb,
    output logic [7:0] o_cr
);
    import rgbnv_pkg::*;

    // Divide by 256, truncating toward zero.
    function automatic logic signed [9:0] div256_tz(input logic signed [17:0] v);
        logic signed [17:0] mag;
        logic signed [9:0]  q;
        mag = v[17] ? -v : v;
        q   = 10'(mag >>> 8);
        return v[17] ? -q : q;
    endfunction

    function automatic logic [7:0] clip8(input logic signed [10:0] v);
        logic [7:0] res;
        if (v < 11'sd0) begin
            res = 8'd0;
        end else if (v > 11'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    logic [15:0]        y_acc;
    logic signed [17:0] sb;
    logic signed [17:0] sg;
    logic signed [17:0] sr;
    logic signed [17:0] cb_acc;
    logic signed [17:0] cr_acc;
    logic signed [10:0] cb_ofs;
    logic signed [10:0] cr_ofs;

    // Luma stays within 128..65408, so the high byte needs no clipping.
    assign y_acc = 16'd54 * 16'(i_red) + 16'd183 * 16'(i_green)
                 + 16'd19 * 16'(i_blue) + 16'd128;
    assign o_luma = y_acc[15:8];

    assign sb = signed'({10'd0, i_blue});
    assign sg = signed'({10'd0, i_green});
    assign sr = signed'({10'd0, i_red});

    assign cb_acc = 18'sd128 * sb - 18'sd29 * sr - 18'sd99 * sg;
    assign cr_acc = 18'sd128 * sr - 18'sd116 * sg - 18'sd12 * sb;

    assign cb_ofs = 11'(div256_tz(cb_acc)) + 11'sd128;
    assign cr_ofs = 11'(div256_tz(cr_acc)) + 11'sd128;

    assign o_cb = clip8(cb_ofs);
    assign o_cr = clip8(cr_ofs);

endmodule

### rtl/rgbnv_checker.sv
module rgbnv_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [1:0]                     o_sample_kind,
    input logic [rgbnv_pkg::OFFSET_W-1:0] o_buffer_offset,
    input logic [rgbnv_pkg::SAMPLE_W-1:0] o_sample_value,
    input logic                           o_run_last,
    input logic                           o_frame_done
);
    import rgbnv_pkg::*;

    logic out_fire;
    assign out_fire = o_valid && i_ready;

    // frame end always falls on the final beat of a pixel
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> o_run_last)
        else $error("frame_done without run_last");

    // a Cb beat never closes a pixel
    a_cb_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sample_kind == KIND_CB) |-> (!o_run_last && !o_frame_done))
        else $error("Cb beat flagged as last");

    // Cr follows its Cb at the next byte
    a_cr_after_cb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_sample_kind == KIND_CB) |=>
        (o_valid && o_sample_kind == KIND_CR &&
         o_buffer_offset == OFFSET_W'($past(o_buffer_offset) + OFFSET_W'(1))))
        else $error("Cr beat does not follow Cb");

    // a stalled beat holds
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
        (o_valid && $stable(o_buffer_offset) && $stable(o_sample_value) &&
         $stable(o_sample_kind)))
        else $error("stalled result beat changed");

endmodule

bind rgb_to_nv12_converter_top rgbnv_checker u_rgbnv_checker (.*);
